// ===== sv/sidechain_binding_table_core_assert.svh =====
// Assertion macros for the side-chain binding table core.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef SIDECHAIN_BINDING_TABLE_CORE_ASSERT_SVH
`define SIDECHAIN_BINDING_TABLE_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SBT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a precondition is followed by a consequence in the next cycle.
`define SBT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/sbt_pkg.sv =====
// Shared types and constants for the side-chain binding table core.
// No dependencies; imported by the top level.
`default_nettype none

package sbt_pkg;

    localparam int MAX_BINDINGS_DEF = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int KCNT_W           = $clog2(MAX_RESULTS + 1);

    localparam int TRACK_W = 32;
    localparam int SLOT_W  = 8;

    // Operation codes
    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_LIST  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_ZERO_TRACK = 2'd1;
    localparam logic [1:0] STAT_FULL       = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [SLOT_W-1:0]  slot;
        logic [TRACK_W-1:0] source;
    } entry_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               src_hit;
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [TRACK_W-1:0] source;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/sidechain_binding_table_core.sv =====
// Side-chain binding table: packed unordered table with swap-with-last delete.
// Zero-track and unused ops skip the scan and go straight to the result;
// other ops scan the entries one per cycle between matches, through the
// single read port. A delete adds a read of the last entry and a write into
// the freed place; a list goes back to the scan after each listed binding
// but the last. One input transaction at a time: a new one is taken only in
// idle, once the previous result is in the output register. Reset clears the
// entry count and control state; entry contents stay undefined, need no clearing.
// Depends on sbt_pkg and sidechain_binding_table_core_assert.svh.
`default_nettype none
`include "sidechain_binding_table_core_assert.svh"

module sidechain_binding_table_core
    import sbt_pkg::*;
#(
    parameter int MAX_BINDINGS = MAX_BINDINGS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // track [31:0], insert_slot [39:32], source_id [71:40]
    input  wire logic [71:0] s_axis_tdata,
    // op [1:0]
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status [1:0], src_hit [2], found [3], out_insert_slot [11:4],
    // out_source_id [43:12], zero fill [47:44]
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam int CNT_W = $clog2(MAX_BINDINGS + 1);
    localparam int IDX_W = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;

    // Entry memory: one write port, one registered read port
    entry_t mem [MAX_BINDINGS];
    entry_t rd_data_reg;
    logic   rd_en;
    logic   [IDX_W-1:0] rd_addr;
    logic   wr_en;
    logic   [IDX_W-1:0] wr_addr;
    entry_t wr_data;

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [KCNT_W-1:0] kcnt_reg, kcnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              out_valid_reg, out_valid_next;

    // Payload state
    logic [1:0]         op_reg, op_next;
    logic [TRACK_W-1:0] trk_reg, trk_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [TRACK_W-1:0] src_reg, src_next;
    logic [CNT_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [SLOT_W-1:0]  pend_slot_reg, pend_slot_next;
    logic [TRACK_W-1:0] pend_src_reg, pend_src_next;
    res_t               res_reg, res_next;
    res_t               out_reg, out_next;

    logic             match;
    logic             hit;
    logic             out_free;
    logic [CNT_W-1:0] last_idx;

    assign last_idx = count_reg - CNT_W'(1);
    assign out_free = !out_valid_reg || m_axis_tready;

    // Compare the entry read last cycle against the held request
    always_comb
    begin
        case (op_reg)
            OP_SET:   match = (rd_data_reg.track == trk_reg) && (rd_data_reg.slot == slot_reg);
            OP_QUERY: match = (rd_data_reg.source == trk_reg);
            OP_LIST:  match = (rd_data_reg.track == trk_reg);
            default:  match = 1'b0;
        endcase
    end

    assign hit = cmp_valid_reg && match;

    // Sequencer: next state, memory ports and result staging
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        kcnt_next       = kcnt_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        trk_next        = trk_reg;
        slot_next       = slot_reg;
        src_next        = src_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_slot_next  = pend_slot_reg;
        pend_src_next   = pend_src_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '{track: trk_reg, slot: slot_reg, source: src_reg};
        s_axis_tready   = (state_reg == ST_IDLE);

        // Drop the output once the downstream side takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next         = s_axis_tuser;
                    trk_next        = s_axis_tdata[31:0];
                    slot_next       = s_axis_tdata[39:32];
                    src_next        = s_axis_tdata[71:40];
                    idx_next        = '0;
                    cmp_valid_next  = 1'b0;
                    kcnt_next       = '0;
                    pend_valid_next = 1'b0;
                    res_next        = '0;
                    res_next.last   = 1'b1;
                    if (s_axis_tuser != OP_SET && s_axis_tuser != OP_QUERY &&
                        s_axis_tuser != OP_LIST)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (s_axis_tdata[31:0] == '0)
                    begin
                        res_next.status = STAT_ZERO_TRACK;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (op_reg == OP_LIST && kcnt_reg == KCNT_W'(MAX_RESULTS))
                begin
                    // Result limit reached: the pending binding closes the list
                    res_next   = '{status: STAT_OK, src_hit: 1'b0, found: 1'b1,
                                   slot: pend_slot_reg, source: pend_src_reg, last: 1'b1};
                    state_next = ST_EMIT;
                end
                else if (hit)
                begin
                    case (op_reg)
                        OP_SET:
                        begin
                            if (src_reg != '0)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = cmp_idx_reg[IDX_W-1:0];
                                res_next   = '0;
                                res_next.last = 1'b1;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_DEL_RD;
                            end
                        end
                        OP_QUERY:
                        begin
                            res_next         = '0;
                            res_next.src_hit = 1'b1;
                            res_next.last    = 1'b1;
                            state_next       = ST_EMIT;
                        end
                        default:
                        begin
                            // Hold the new match back until the next one or the end
                            kcnt_next       = kcnt_reg + KCNT_W'(1);
                            pend_valid_next = 1'b1;
                            pend_slot_next  = rd_data_reg.slot;
                            pend_src_next   = rd_data_reg.source;
                            idx_next        = cmp_idx_reg + CNT_W'(1);
                            cmp_valid_next  = 1'b0;
                            if (pend_valid_reg)
                            begin
                                res_next   = '{status: STAT_OK, src_hit: 1'b0,
                                               found: 1'b1, slot: pend_slot_reg,
                                               source: pend_src_reg, last: 1'b0};
                                state_next = ST_EMIT;
                            end
                        end
                    endcase
                end
                else if (idx_reg < count_reg)
                begin
                    // Advance the scan one entry
                    rd_en          = 1'b1;
                    rd_addr        = idx_reg[IDX_W-1:0];
                    cmp_idx_next   = idx_reg;
                    idx_next       = idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                end
                else if (cmp_valid_reg)
                begin
                    cmp_valid_next = 1'b0;
                end
                else
                begin
                    // Scan finished without an early exit
                    res_next      = '0;
                    res_next.last = 1'b1;
                    state_next    = ST_EMIT;
                    case (op_reg)
                        OP_SET:
                        begin
                            if (src_reg != '0)
                            begin
                                if (count_reg >= CNT_W'(MAX_BINDINGS))
                                begin
                                    res_next.status = STAT_FULL;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = count_reg[IDX_W-1:0];
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            res_next.src_hit = 1'b0;
                        end
                        default:
                        begin
                            if (pend_valid_reg)
                            begin
                                res_next.found  = 1'b1;
                                res_next.slot   = pend_slot_reg;
                                res_next.source = pend_src_reg;
                            end
                        end
                    endcase
                end
            end

            ST_DEL_RD:
            begin
                // Fetch the last entry to fill the freed place
                rd_en      = 1'b1;
                rd_addr    = last_idx[IDX_W-1:0];
                state_next = ST_DEL_WR;
            end

            ST_DEL_WR:
            begin
                wr_en         = 1'b1;
                wr_addr       = cmp_idx_reg[IDX_W-1:0];
                wr_data       = rd_data_reg;
                count_next    = last_idx;
                res_next      = '0;
                res_next.last = 1'b1;
                state_next    = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = res_reg.last ? ST_IDLE : ST_SCAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            kcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            kcnt_reg       <= kcnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        trk_reg       <= trk_next;
        slot_reg      <= slot_next;
        src_reg       <= src_next;
        cmp_idx_reg   <= cmp_idx_next;
        pend_slot_reg <= pend_slot_next;
        pend_src_reg  <= pend_src_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    // Output channel
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {4'b0000, out_reg.source, out_reg.slot, out_reg.found,
                            out_reg.src_hit, out_reg.status};

    // Checks
    `SBT_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_BINDINGS),
        "entry count above table depth")
    `SBT_ASSERT_ALWAYS(a_del_nonempty, state_reg != ST_DEL_RD || count_reg != '0,
        "delete started on an empty table")
    `SBT_ASSERT_NEXT(a_del_shrinks, state_reg == ST_DEL_WR,
        count_reg == $past(count_reg) - CNT_W'(1), "delete did not decrement count")
    `SBT_ASSERT_ALWAYS(a_list_bound, kcnt_reg <= KCNT_W'(MAX_RESULTS),
        "listed bindings above result limit")
    `SBT_ASSERT_ALWAYS(a_mid_is_found, !out_valid_reg || out_reg.last || out_reg.found,
        "non-final result without a binding")

endmodule

`default_nettype wire
